// ===== rtl/qau_pkg.sv =====
// Package for the quaternion arithmetic unit: widths, command and status codes,
// request, result and pipeline payload types, and the saturation function.
// No dependencies.
package qau_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int LANES     = 4;
    localparam int CMD_W     = 4;
    localparam int STATUS_W  = 2;
    localparam int CFG_W     = 17;
    localparam int IDX_W     = 2;

    localparam int PROD_W     = 2 * DATA_W;
    localparam int SQ_W       = PROD_W + 1;
    localparam int SUM_W      = PROD_W + 3;
    localparam int EARLY_W    = SUM_W - FRAC_BITS;
    localparam int NSQ_W      = SQ_W - FRAC_BITS + 1;
    localparam int NRM_W      = DATA_W + 1;
    localparam int SHIFT_W    = DATA_W + FRAC_BITS + 1;
    localparam int NUM_W      = ((SHIFT_W > NSQ_W) ? SHIFT_W : NSQ_W) + 1;
    localparam int DEN_W      = NSQ_W;
    localparam int DVS_W      = DEN_W + 1;
    localparam int REM_W      = DVS_W;
    localparam int WIDE_W     = ((EARLY_W > NUM_W) ? EARLY_W : NUM_W) + 1;
    localparam int SQRT_STEPS = DATA_W;

    localparam logic [CMD_W-1:0] CMD_ADD       = 4'd0;
    localparam logic [CMD_W-1:0] CMD_SUB       = 4'd1;
    localparam logic [CMD_W-1:0] CMD_SCALE     = 4'd2;
    localparam logic [CMD_W-1:0] CMD_DIVIDE    = 4'd3;
    localparam logic [CMD_W-1:0] CMD_PRODUCT   = 4'd4;
    localparam logic [CMD_W-1:0] CMD_INVERSE   = 4'd5;
    localparam logic [CMD_W-1:0] CMD_NORMALIZE = 4'd6;
    localparam logic [CMD_W-1:0] CMD_NORM      = 4'd7;
    localparam logic [CMD_W-1:0] CMD_EQUAL     = 4'd8;
    localparam logic [CMD_W-1:0] CMD_UNIT      = 4'd9;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DIVZ = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SAT  = 2'd2;

    localparam logic [IDX_W-1:0] CFG_ZERO_THR  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_EQUAL_TOL = 2'd1;
    localparam logic [IDX_W-1:0] CFG_UNIT_TOL  = 2'd2;

    // Negated terms of the Hamilton product, indexed by row and then term.
    localparam logic [LANES-1:0][LANES-1:0] PROD_NEG = {4'b0100, 4'b0010, 4'b1000, 4'b1110};

    localparam logic [PROD_W-1:0] ONE_SQ   = PROD_W'(1) << (2 * FRAC_BITS);
    localparam logic [SUM_W-1:0]  HALF_LSB = SUM_W'(1) << (FRAC_BITS - 1);
    localparam logic [NRM_W-1:0]  NRM_MAX  = NRM_W'(1) << DATA_W;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic signed [DATA_W-1:0] a_real;
        logic signed [DATA_W-1:0] a_first;
        logic signed [DATA_W-1:0] a_second;
        logic signed [DATA_W-1:0] a_third;
        logic signed [DATA_W-1:0] b_real;
        logic signed [DATA_W-1:0] b_first;
        logic signed [DATA_W-1:0] b_second;
        logic signed [DATA_W-1:0] b_third;
        logic signed [DATA_W-1:0] scalar_value;
    } request_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_real;
        logic signed [DATA_W-1:0] out_first;
        logic signed [DATA_W-1:0] out_second;
        logic signed [DATA_W-1:0] out_third;
        logic                     test_flag;
        logic [STATUS_W-1:0]      status;
    } result_t;

    typedef struct packed {
        logic [CMD_W-1:0]                 command;
        logic [LANES-1:0][EARLY_W-1:0]    early;
        logic                             flag;
        logic                             divz;
        logic                             s_neg;
        logic [DATA_W-1:0]                ms;
        logic [NSQ_W-1:0]                 nsq;
        logic                             carry;
        logic [LANES-1:0][DATA_W-1:0]     a;
    } mid_t;

    typedef struct packed {
        logic [CMD_W-1:0]              command;
        logic [LANES-1:0][EARLY_W-1:0] early;
        logic                          flag;
        logic                          divz;
        logic                          zero;
        logic [LANES-1:0]              neg;
        logic [NRM_W-1:0]              nrm;
    } tail_t;

    typedef struct packed {
        logic              sat;
        logic [DATA_W-1:0] val;
    } sat_t;

    function automatic sat_t saturate(input logic [WIDE_W-1:0] v);
        sat_t r;
        logic hi_zero;
        logic hi_ones;
        hi_zero = ~|v[WIDE_W-1:DATA_W-1];
        hi_ones = &v[WIDE_W-1:DATA_W-1];
        if (hi_zero || hi_ones) begin
            r.sat = 1'b0;
            r.val = v[DATA_W-1:0];
        end else if (v[WIDE_W-1]) begin
            r.sat = 1'b1;
            r.val = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            r.sat = 1'b1;
            r.val = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// ===== rtl/quaternion_arithmetic_unit_core.sv =====
// Top level of the quaternion arithmetic unit: configuration registers, divider
// operand setup and result saturation around the front, root and divide pipes.
// Depends on qau_pkg, qau_front, qau_sqrt and qau_div.
//
// Channel   Handshake            Payload
// request   start, busy          request (qau_pkg::request_t)
// result    done strobe          result (qau_pkg::result_t)
// config    cfg_valid, cfg_ready cfg_index, cfg_data
//
// One request is taken every cycle; busy is always low and cfg_ready always high.
// Operands carry 16 fraction bits; each request passes through the front pipe, the
// bit-per-stage root pipe, setup register, bit-per-stage divide pipe and result register.
// Results leave in request order, one per done strobe, and cannot be held off.
// Reset clears the valid bits and loads the register defaults.
module quaternion_arithmetic_unit_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  qau_pkg::request_t            request,
    output logic                         done,
    output qau_pkg::result_t             result,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [qau_pkg::IDX_W-1:0]    cfg_index,
    input  logic [qau_pkg::CFG_W-1:0]    cfg_data
);

    logic [qau_pkg::CFG_W-1:0] zero_thr_reg;
    logic [qau_pkg::CFG_W-1:0] equal_tol_reg;
    logic [qau_pkg::CFG_W-1:0] unit_tol_reg;

    logic                       front_valid;
    qau_pkg::mid_t              front_mid;
    logic [qau_pkg::PROD_W-1:0] front_sq;

    logic                       root_valid;
    qau_pkg::mid_t              root_mid;
    logic [qau_pkg::NRM_W-1:0]  root_norm;

    logic [qau_pkg::LANES-1:0][qau_pkg::NUM_W-1:0] num_next;
    logic [qau_pkg::LANES-1:0][qau_pkg::NUM_W-1:0] num_reg;
    logic [qau_pkg::DEN_W-1:0]                     den_next;
    logic [qau_pkg::DEN_W-1:0]                     den_reg;
    qau_pkg::tail_t                                tail_next;
    qau_pkg::tail_t                                tail_reg;
    logic                                          setup_vld_reg;

    logic                                          div_valid;
    qau_pkg::tail_t                                div_tail;
    logic [qau_pkg::LANES-1:0][qau_pkg::NUM_W-1:0] div_quot;

    qau_pkg::result_t result_next;
    qau_pkg::result_t result_reg;
    logic             done_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_thr_reg  <= qau_pkg::CFG_W'(1);
            equal_tol_reg <= qau_pkg::CFG_W'(1);
            unit_tol_reg  <= qau_pkg::CFG_W'(66);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                qau_pkg::CFG_ZERO_THR:  zero_thr_reg  <= cfg_data;
                qau_pkg::CFG_EQUAL_TOL: equal_tol_reg <= cfg_data;
                qau_pkg::CFG_UNIT_TOL:  unit_tol_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    qau_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (start && !busy),
        .request         (request),
        .zero_threshold  (zero_thr_reg),
        .equal_tolerance (equal_tol_reg),
        .unit_tolerance  (unit_tol_reg),
        .out_valid       (front_valid),
        .mid             (front_mid),
        .sq_low          (front_sq)
    );

    qau_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .sq_low    (front_sq),
        .mid_in    (front_mid),
        .out_valid (root_valid),
        .mid_out   (root_mid),
        .norm      (root_norm)
    );

    always_comb
    begin
        logic [qau_pkg::DATA_W-1:0] mag;
        logic [qau_pkg::DATA_W-1:0] av;
        logic                       a_neg;
        den_next          = '0;
        tail_next.command = root_mid.command;
        tail_next.early   = root_mid.early;
        tail_next.flag    = root_mid.flag;
        tail_next.divz    = root_mid.divz;
        tail_next.zero    = 1'b0;
        tail_next.neg     = '0;
        tail_next.nrm     = root_norm;
        case (root_mid.command)
            qau_pkg::CMD_DIVIDE:    den_next = qau_pkg::DEN_W'(root_mid.ms);
            qau_pkg::CMD_INVERSE:
            begin
                den_next       = root_mid.nsq;
                tail_next.zero = root_mid.nsq < qau_pkg::NSQ_W'(zero_thr_reg);
            end
            qau_pkg::CMD_NORMALIZE:
            begin
                den_next       = qau_pkg::DEN_W'(root_norm);
                tail_next.zero = root_norm < qau_pkg::NRM_W'(zero_thr_reg);
            end
            default:                den_next = '0;
        endcase
        for (int l = 0; l < qau_pkg::LANES; l++)
        begin
            av    = root_mid.a[l];
            a_neg = av[qau_pkg::DATA_W-1];
            mag   = a_neg ? (qau_pkg::DATA_W)'(0 - av) : av;
            if (root_mid.command == qau_pkg::CMD_DIVIDE)
            begin
                tail_next.neg[l] = a_neg ^ root_mid.s_neg;
            end
            else if (root_mid.command == qau_pkg::CMD_INVERSE && l != 0)
            begin
                tail_next.neg[l] = !a_neg && (|av);
            end
            else
            begin
                tail_next.neg[l] = a_neg;
            end
            num_next[l] = (qau_pkg::NUM_W'(mag) << (qau_pkg::FRAC_BITS + 1))
                        + qau_pkg::NUM_W'(den_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setup_vld_reg <= 1'b0;
        end
        else
        begin
            setup_vld_reg <= root_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        den_reg  <= den_next;
        tail_reg <= tail_next;
    end

    qau_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (setup_vld_reg),
        .num       (num_reg),
        .den       (den_reg),
        .tail_in   (tail_reg),
        .out_valid (div_valid),
        .tail_out  (div_tail),
        .quot      (div_quot)
    );

    always_comb
    begin
        logic [qau_pkg::WIDE_W-1:0] wide [qau_pkg::LANES];
        logic [qau_pkg::WIDE_W-1:0] dres [qau_pkg::LANES];
        logic [qau_pkg::WIDE_W-1:0] ew   [qau_pkg::LANES];
        logic [qau_pkg::WIDE_W-1:0] qv;
        qau_pkg::sat_t              sr   [qau_pkg::LANES];
        logic [qau_pkg::STATUS_W-1:0] st;
        logic                       flag;
        logic                       any_sat;
        st   = qau_pkg::ST_OK;
        flag = 1'b0;
        for (int l = 0; l < qau_pkg::LANES; l++)
        begin
            qv      = qau_pkg::WIDE_W'(div_quot[l]);
            dres[l] = div_tail.neg[l] ? (qau_pkg::WIDE_W)'(0 - qv) : qv;
            ew[l]   = qau_pkg::WIDE_W'($signed(div_tail.early[l]));
            wide[l] = '0;
        end
        case (div_tail.command)
            qau_pkg::CMD_ADD, qau_pkg::CMD_SUB, qau_pkg::CMD_SCALE, qau_pkg::CMD_PRODUCT:
            begin
                wide = ew;
            end
            qau_pkg::CMD_DIVIDE:
            begin
                if (div_tail.divz)
                begin
                    st = qau_pkg::ST_DIVZ;
                end
                else
                begin
                    wide = dres;
                end
            end
            qau_pkg::CMD_INVERSE, qau_pkg::CMD_NORMALIZE:
            begin
                if (!div_tail.zero)
                begin
                    wide = dres;
                end
            end
            qau_pkg::CMD_NORM:
            begin
                wide[0] = qau_pkg::WIDE_W'(div_tail.nrm);
            end
            qau_pkg::CMD_EQUAL, qau_pkg::CMD_UNIT:
            begin
                flag = div_tail.flag;
            end
            default: ;
        endcase
        any_sat = 1'b0;
        for (int l = 0; l < qau_pkg::LANES; l++)
        begin
            sr[l]   = qau_pkg::saturate(wide[l]);
            any_sat = any_sat | sr[l].sat;
        end
        if (any_sat && st == qau_pkg::ST_OK)
        begin
            st = qau_pkg::ST_SAT;
        end
        result_next.out_real   = sr[0].val;
        result_next.out_first  = sr[1].val;
        result_next.out_second = sr[2].val;
        result_next.out_third  = sr[3].val;
        result_next.test_flag  = flag;
        result_next.status     = st;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/qau_front.sv =====
// Front end of the quaternion unit: request register, sixteen multipliers,
// and the rounded sums, squared norm and test flags.
// Depends on qau_pkg.
module qau_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  qau_pkg::request_t            request,
    input  logic [qau_pkg::CFG_W-1:0]    zero_threshold,
    input  logic [qau_pkg::CFG_W-1:0]    equal_tolerance,
    input  logic [qau_pkg::CFG_W-1:0]    unit_tolerance,
    output logic                         out_valid,
    output qau_pkg::mid_t                mid,
    output logic [qau_pkg::PROD_W-1:0]   sq_low
);

    qau_pkg::request_t req_reg;
    qau_pkg::request_t req2_reg;
    logic              v1_reg;
    logic              v2_reg;
    logic              v3_reg;

    logic signed [qau_pkg::DATA_W-1:0] a_lane [qau_pkg::LANES];
    logic signed [qau_pkg::DATA_W-1:0] b_lane [qau_pkg::LANES];

    logic signed [qau_pkg::PROD_W-1:0] prod_next [qau_pkg::LANES][qau_pkg::LANES];
    logic signed [qau_pkg::PROD_W-1:0] prod_reg  [qau_pkg::LANES][qau_pkg::LANES];
    logic signed [qau_pkg::DATA_W:0]   addsub_next [qau_pkg::LANES];
    logic signed [qau_pkg::DATA_W:0]   addsub_reg  [qau_pkg::LANES];
    logic                              eq_next;
    logic                              eq_reg;
    logic [qau_pkg::DATA_W-1:0]        ms_next;
    logic [qau_pkg::DATA_W-1:0]        ms_reg;
    logic                              divz_next;
    logic                              divz_reg;
    logic [2*qau_pkg::CFG_W-1:0]       ut_sq_reg;

    qau_pkg::mid_t                     mid_next;
    qau_pkg::mid_t                     mid_reg;
    logic [qau_pkg::SQ_W-1:0]          sq_next;
    logic [qau_pkg::PROD_W-1:0]        sq_reg;

    assign a_lane[0] = req_reg.a_real;
    assign a_lane[1] = req_reg.a_first;
    assign a_lane[2] = req_reg.a_second;
    assign a_lane[3] = req_reg.a_third;
    assign b_lane[0] = req_reg.b_real;
    assign b_lane[1] = req_reg.b_first;
    assign b_lane[2] = req_reg.b_second;
    assign b_lane[3] = req_reg.b_third;

    always_comb
    begin
        logic signed [qau_pkg::DATA_W-1:0] y;
        logic signed [qau_pkg::DATA_W:0]   sum;
        logic signed [qau_pkg::DATA_W:0]   dif;
        logic [qau_pkg::DATA_W:0]          mag;
        eq_next = 1'b1;
        for (int r = 0; r < qau_pkg::LANES; r++)
        begin
            for (int t = 0; t < qau_pkg::LANES; t++)
            begin
                if (req_reg.command == qau_pkg::CMD_PRODUCT)
                begin
                    y = b_lane[r ^ t];
                end
                else if (r == 0)
                begin
                    y = a_lane[t];
                end
                else
                begin
                    y = req_reg.scalar_value;
                end
                prod_next[r][t] = a_lane[t] * y;
            end
        end
        for (int c = 0; c < qau_pkg::LANES; c++)
        begin
            sum = {a_lane[c][qau_pkg::DATA_W-1], a_lane[c]} + {b_lane[c][qau_pkg::DATA_W-1], b_lane[c]};
            dif = {a_lane[c][qau_pkg::DATA_W-1], a_lane[c]} - {b_lane[c][qau_pkg::DATA_W-1], b_lane[c]};
            mag = dif[qau_pkg::DATA_W] ? -dif : dif;
            if (!(mag < (qau_pkg::DATA_W+1)'(equal_tolerance)))
            begin
                eq_next = 1'b0;
            end
            addsub_next[c] = (req_reg.command == qau_pkg::CMD_SUB) ? dif : sum;
        end
        ms_next = req_reg.scalar_value[qau_pkg::DATA_W-1] ?
                  (qau_pkg::DATA_W)'(-req_reg.scalar_value) : req_reg.scalar_value;
        divz_next = ms_next < qau_pkg::DATA_W'(zero_threshold);
    end

    always_comb
    begin
        logic signed [qau_pkg::SUM_W-1:0] acc;
        logic signed [qau_pkg::SUM_W-1:0] term;
        logic [qau_pkg::PROD_W-1:0]       diff;
        logic                             unit;
        logic [qau_pkg::EARLY_W-1:0]      row_res [qau_pkg::LANES];
        logic [qau_pkg::EARLY_W-1:0]      scale_res [qau_pkg::LANES];
        for (int r = 0; r < qau_pkg::LANES; r++)
        begin
            acc = qau_pkg::HALF_LSB;
            for (int t = 0; t < qau_pkg::LANES; t++)
            begin
                term = qau_pkg::SUM_W'(prod_reg[r][t]);
                acc = qau_pkg::PROD_NEG[r][t] ? acc - term : acc + term;
            end
            row_res[r] = acc[qau_pkg::SUM_W-1:qau_pkg::FRAC_BITS];
            acc = qau_pkg::HALF_LSB + qau_pkg::SUM_W'(prod_reg[1][r]);
            scale_res[r] = acc[qau_pkg::SUM_W-1:qau_pkg::FRAC_BITS];
        end
        sq_next = '0;
        for (int t = 0; t < qau_pkg::LANES; t++)
        begin
            sq_next = sq_next + qau_pkg::SQ_W'($unsigned(prod_reg[0][t]));
        end
        diff = (sq_next[qau_pkg::PROD_W-1:0] >= qau_pkg::ONE_SQ) ?
               sq_next[qau_pkg::PROD_W-1:0] - qau_pkg::ONE_SQ :
               qau_pkg::ONE_SQ - sq_next[qau_pkg::PROD_W-1:0];
        unit = !sq_next[qau_pkg::SQ_W-1] && (diff < qau_pkg::PROD_W'(ut_sq_reg));

        mid_next.command = req2_reg.command;
        for (int c = 0; c < qau_pkg::LANES; c++)
        begin
            if (req2_reg.command == qau_pkg::CMD_PRODUCT)
            begin
                mid_next.early[c] = row_res[c];
            end
            else if (req2_reg.command == qau_pkg::CMD_SCALE)
            begin
                mid_next.early[c] = scale_res[c];
            end
            else
            begin
                mid_next.early[c] = qau_pkg::EARLY_W'(addsub_reg[c]);
            end
        end
        if (req2_reg.command == qau_pkg::CMD_EQUAL)
        begin
            mid_next.flag = eq_reg;
        end
        else if (req2_reg.command == qau_pkg::CMD_UNIT)
        begin
            mid_next.flag = unit;
        end
        else
        begin
            mid_next.flag = 1'b0;
        end
        mid_next.divz  = divz_reg;
        mid_next.s_neg = req2_reg.scalar_value[qau_pkg::DATA_W-1];
        mid_next.ms    = ms_reg;
        mid_next.nsq   = qau_pkg::NSQ_W'(sq_next[qau_pkg::SQ_W-1:qau_pkg::FRAC_BITS])
                       + qau_pkg::NSQ_W'(sq_next[qau_pkg::FRAC_BITS-1]);
        mid_next.carry = sq_next[qau_pkg::SQ_W-1];
        mid_next.a[0]  = req2_reg.a_real;
        mid_next.a[1]  = req2_reg.a_first;
        mid_next.a[2]  = req2_reg.a_second;
        mid_next.a[3]  = req2_reg.a_third;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= request;
        req2_reg  <= req_reg;
        prod_reg  <= prod_next;
        addsub_reg <= addsub_next;
        eq_reg    <= eq_next;
        ms_reg    <= ms_next;
        divz_reg  <= divz_next;
        ut_sq_reg <= (2*qau_pkg::CFG_W)'(unit_tolerance) * (2*qau_pkg::CFG_W)'(unit_tolerance);
        mid_reg   <= mid_next;
        sq_reg    <= sq_next[qau_pkg::PROD_W-1:0];
    end

    assign out_valid = v3_reg;
    assign mid       = mid_reg;
    assign sq_low    = sq_reg;

endmodule

// ===== rtl/qau_sqrt.sv =====
// Pipelined integer square root of the squared norm, one result bit per stage,
// followed by a rounding stage that yields the norm.
// Depends on qau_pkg.
module qau_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [qau_pkg::PROD_W-1:0]  sq_low,
    input  qau_pkg::mid_t               mid_in,
    output logic                        out_valid,
    output qau_pkg::mid_t               mid_out,
    output logic [qau_pkg::NRM_W-1:0]   norm
);

    logic [qau_pkg::PROD_W-1:0] rad_reg  [qau_pkg::SQRT_STEPS];
    logic [qau_pkg::PROD_W-1:0] root_reg [qau_pkg::SQRT_STEPS];
    qau_pkg::mid_t              mid_reg  [qau_pkg::SQRT_STEPS];
    logic                       vld_reg  [qau_pkg::SQRT_STEPS];

    logic                       out_vld_reg;
    qau_pkg::mid_t              out_mid_reg;
    logic [qau_pkg::NRM_W-1:0]  norm_reg;
    logic [qau_pkg::NRM_W-1:0]  norm_next;

    for (genvar k = 0; k < qau_pkg::SQRT_STEPS; k++)
    begin : g_step
        localparam logic [qau_pkg::PROD_W-1:0] STEP_BIT =
            qau_pkg::PROD_W'(1) << (qau_pkg::PROD_W - 2 - 2*k);
        logic [qau_pkg::PROD_W-1:0] rad_in;
        logic [qau_pkg::PROD_W-1:0] root_in;
        qau_pkg::mid_t              mid_k;
        logic                       vld_in;
        logic [qau_pkg::PROD_W:0]   trial;
        logic [qau_pkg::PROD_W-1:0] rad_next;
        logic [qau_pkg::PROD_W-1:0] root_next;

        if (k == 0)
        begin : g_first
            assign rad_in  = sq_low;
            assign root_in = '0;
            assign mid_k   = mid_in;
            assign vld_in  = in_valid;
        end
        else
        begin : g_rest
            assign rad_in  = rad_reg[k-1];
            assign root_in = root_reg[k-1];
            assign mid_k   = mid_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        always_comb
        begin
            trial = {1'b0, root_in} + {1'b0, STEP_BIT};
            if ({1'b0, rad_in} >= trial)
            begin
                rad_next  = rad_in - trial[qau_pkg::PROD_W-1:0];
                root_next = (root_in >> 1) + STEP_BIT;
            end
            else
            begin
                rad_next  = rad_in;
                root_next = root_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rad_reg[k]  <= rad_next;
            root_reg[k] <= root_next;
            mid_reg[k]  <= mid_k;
        end
    end

    always_comb
    begin
        logic [qau_pkg::PROD_W-1:0] rad;
        logic [qau_pkg::PROD_W-1:0] root;
        rad  = rad_reg[qau_pkg::SQRT_STEPS-1];
        root = root_reg[qau_pkg::SQRT_STEPS-1];
        if (mid_reg[qau_pkg::SQRT_STEPS-1].carry)
        begin
            norm_next = qau_pkg::NRM_MAX;
        end
        else
        begin
            norm_next = root[qau_pkg::NRM_W-1:0] + qau_pkg::NRM_W'(rad > root);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= vld_reg[qau_pkg::SQRT_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        out_mid_reg <= mid_reg[qau_pkg::SQRT_STEPS-1];
        norm_reg    <= norm_next;
    end

    assign out_valid = out_vld_reg;
    assign mid_out   = out_mid_reg;
    assign norm      = norm_reg;

endmodule

// ===== rtl/qau_div.sv =====
// Four-lane pipelined restoring divider with a shared divisor, one quotient
// bit per stage; the divisor is twice the given denominator.
// Depends on qau_pkg.
module qau_div (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           in_valid,
    input  logic [qau_pkg::LANES-1:0][qau_pkg::NUM_W-1:0]  num,
    input  logic [qau_pkg::DEN_W-1:0]                      den,
    input  qau_pkg::tail_t                                 tail_in,
    output logic                                           out_valid,
    output qau_pkg::tail_t                                 tail_out,
    output logic [qau_pkg::LANES-1:0][qau_pkg::NUM_W-1:0]  quot
);

    logic [qau_pkg::LANES-1:0][qau_pkg::NUM_W-1:0] wq_reg   [qau_pkg::NUM_W];
    logic [qau_pkg::LANES-1:0][qau_pkg::REM_W-1:0] rem_reg  [qau_pkg::NUM_W];
    logic [qau_pkg::DVS_W-1:0]                     dvs_reg  [qau_pkg::NUM_W];
    qau_pkg::tail_t                                tail_reg [qau_pkg::NUM_W];
    logic                                          vld_reg  [qau_pkg::NUM_W];

    for (genvar k = 0; k < qau_pkg::NUM_W; k++)
    begin : g_step
        logic [qau_pkg::LANES-1:0][qau_pkg::NUM_W-1:0] wq_in;
        logic [qau_pkg::LANES-1:0][qau_pkg::REM_W-1:0] rem_in;
        logic [qau_pkg::DVS_W-1:0]                     dvs_in;
        qau_pkg::tail_t                                tail_k;
        logic                                          vld_in;
        logic [qau_pkg::LANES-1:0][qau_pkg::NUM_W-1:0] wq_next;
        logic [qau_pkg::LANES-1:0][qau_pkg::REM_W-1:0] rem_next;

        if (k == 0)
        begin : g_first
            assign wq_in  = num;
            assign rem_in = '0;
            assign dvs_in = {den, 1'b0};
            assign tail_k = tail_in;
            assign vld_in = in_valid;
        end
        else
        begin : g_rest
            assign wq_in  = wq_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign dvs_in = dvs_reg[k-1];
            assign tail_k = tail_reg[k-1];
            assign vld_in = vld_reg[k-1];
        end

        always_comb
        begin
            logic [qau_pkg::REM_W:0] trial;
            logic [qau_pkg::REM_W:0] diff;
            logic                    ge;
            for (int l = 0; l < qau_pkg::LANES; l++)
            begin
                trial = {rem_in[l], wq_in[l][qau_pkg::NUM_W-1]};
                diff  = trial - {1'b0, dvs_in};
                ge    = trial >= {1'b0, dvs_in};
                rem_next[l] = ge ? diff[qau_pkg::REM_W-1:0] : trial[qau_pkg::REM_W-1:0];
                wq_next[l]  = {wq_in[l][qau_pkg::NUM_W-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            wq_reg[k]   <= wq_next;
            rem_reg[k]  <= rem_next;
            dvs_reg[k]  <= dvs_in;
            tail_reg[k] <= tail_k;
        end
    end

    assign out_valid = vld_reg[qau_pkg::NUM_W-1];
    assign tail_out  = tail_reg[qau_pkg::NUM_W-1];
    assign quot      = wq_reg[qau_pkg::NUM_W-1];

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the quaternion arithmetic unit: directed and random
// requests against a fixed-point predictor, over several register settings.
// Depends on qau_pkg and quaternion_arithmetic_unit_core.
`timescale 1ns / 100ps

module testbench;

    typedef logic signed [127:0] wide_t;
    typedef logic [127:0]        uwide_t;

    localparam int    LIMIT  = 200000;
    localparam wide_t HALF   = 128'sd32768;
    localparam wide_t WMAX   = 128'sd2147483647;
    localparam wide_t WMIN   = -128'sd2147483648;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    qau_pkg::request_t          request = '0;
    logic                       done;
    qau_pkg::result_t           result;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [qau_pkg::IDX_W-1:0]  cfg_index = '0;
    logic [qau_pkg::CFG_W-1:0]  cfg_data = '0;

    logic [qau_pkg::CFG_W-1:0]  zero_thr = 17'd1;
    logic [qau_pkg::CFG_W-1:0]  eq_tol = 17'd1;
    logic [qau_pkg::CFG_W-1:0]  unit_tol = 17'd66;

    qau_pkg::request_t          pending[$];
    qau_pkg::result_t           awaited[$];
    logic                       took = 1'b0;
    logic                       quiet = 1'b0;
    int                         errors = 0;
    int                         cycles = 0;

    quaternion_arithmetic_unit_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic wide_t round_frac(input wide_t v);
        return (v + HALF) >>> qau_pkg::FRAC_BITS;
    endfunction

    function automatic wide_t div_round(input wide_t x, input uwide_t d);
        uwide_t m;
        uwide_t q;
        m = (x < 0) ? uwide_t'(-x) : uwide_t'(x);
        q = ((m << (qau_pkg::FRAC_BITS + 1)) + d) / (d << 1);
        return (x < 0) ? -wide_t'(q) : wide_t'(q);
    endfunction

    function automatic uwide_t int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = '0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return uwide_t'(r);
    endfunction

    function automatic qau_pkg::result_t quat_eval(input qau_pkg::request_t rq);
        qau_pkg::result_t o;
        wide_t   a[4];
        wide_t   b[4];
        wide_t   res[4];
        wide_t   s;
        wide_t   d;
        uwide_t  sq;
        uwide_t  nsq;
        uwide_t  nrm;
        uwide_t  ms;
        uwide_t  one2;
        uwide_t  diff;
        logic    carry;
        logic    sat;
        logic    flag;
        logic [qau_pkg::STATUS_W-1:0] st;
        a = '{wide_t'(rq.a_real), wide_t'(rq.a_first), wide_t'(rq.a_second),
              wide_t'(rq.a_third)};
        b = '{wide_t'(rq.b_real), wide_t'(rq.b_first), wide_t'(rq.b_second),
              wide_t'(rq.b_third)};
        s = wide_t'(rq.scalar_value);
        res = '{default: '0};
        flag = 1'b0;
        st = qau_pkg::ST_OK;
        sat = 1'b0;
        sq = '0;
        for (int c = 0; c < 4; c++)
            sq = sq + uwide_t'(a[c] * a[c]);
        carry = sq[64];
        nsq = (sq + uwide_t'(HALF)) >> qau_pkg::FRAC_BITS;
        if (carry)
            nrm = uwide_t'(1) << 32;
        else
        begin
            nrm = int_sqrt(sq[63:0]);
            if (sq - nrm * nrm > nrm)
                nrm = nrm + 1;
        end
        case (rq.command)
            qau_pkg::CMD_ADD:
                for (int c = 0; c < 4; c++)
                    res[c] = a[c] + b[c];
            qau_pkg::CMD_SUB:
                for (int c = 0; c < 4; c++)
                    res[c] = a[c] - b[c];
            qau_pkg::CMD_SCALE:
                for (int c = 0; c < 4; c++)
                    res[c] = round_frac(a[c] * s);
            qau_pkg::CMD_DIVIDE:
            begin
                ms = (s < 0) ? uwide_t'(-s) : uwide_t'(s);
                if (ms < uwide_t'(zero_thr) || ms == 0)
                    st = qau_pkg::ST_DIVZ;
                else
                    for (int c = 0; c < 4; c++)
                        res[c] = (s < 0) ? -div_round(a[c], ms) : div_round(a[c], ms);
            end
            qau_pkg::CMD_PRODUCT:
            begin
                res[0] = round_frac(a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3]);
                res[1] = round_frac(a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2]);
                res[2] = round_frac(a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1]);
                res[3] = round_frac(a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0]);
            end
            qau_pkg::CMD_INVERSE:
                if (!(nsq < uwide_t'(zero_thr)) && nsq != 0)
                begin
                    res[0] = div_round(a[0], nsq);
                    for (int c = 1; c < 4; c++)
                        res[c] = div_round(-a[c], nsq);
                end
            qau_pkg::CMD_NORMALIZE:
                if (!(nrm < uwide_t'(zero_thr)) && nrm != 0)
                    for (int c = 0; c < 4; c++)
                        res[c] = div_round(a[c], nrm);
            qau_pkg::CMD_NORM:
                res[0] = wide_t'(nrm);
            qau_pkg::CMD_EQUAL:
            begin
                flag = 1'b1;
                for (int c = 0; c < 4; c++)
                begin
                    d = a[c] - b[c];
                    if (!(((d < 0) ? uwide_t'(-d) : uwide_t'(d)) < uwide_t'(eq_tol)))
                        flag = 1'b0;
                end
            end
            qau_pkg::CMD_UNIT:
                if (!carry)
                begin
                    one2 = uwide_t'(1) << (2 * qau_pkg::FRAC_BITS);
                    diff = (sq >= one2) ? sq - one2 : one2 - sq;
                    flag = diff < uwide_t'(unit_tol) * uwide_t'(unit_tol);
                end
            default:
                ;
        endcase
        for (int c = 0; c < 4; c++)
        begin
            if (res[c] > WMAX)
            begin
                res[c] = WMAX;
                sat = 1'b1;
            end
            else if (res[c] < WMIN)
            begin
                res[c] = WMIN;
                sat = 1'b1;
            end
        end
        if (sat && st == qau_pkg::ST_OK)
            st = qau_pkg::ST_SAT;
        o.out_real = res[0][31:0];
        o.out_first = res[1][31:0];
        o.out_second = res[2][31:0];
        o.out_third = res[3][31:0];
        o.test_flag = flag;
        o.status = st;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        took <= start && !busy;
        if (rst_n && start && !busy)
            awaited.push_back(quat_eval(request));
    end

    always @(negedge clk)
    begin
        if (rst_n && (!start || took))
        begin
            if (pending.size() > 0 && (quiet || $urandom_range(0, 99) >= 7))
            begin
                request <= pending.pop_front();
                start <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        qau_pkg::result_t want;
        if (rst_n && done)
        begin
            if (awaited.size() == 0)
                report_mismatch("unexpected result", result.out_real, '0);
            else
            begin
                want = awaited.pop_front();
                if (result.out_real !== want.out_real)
                    report_mismatch("out_real", result.out_real, want.out_real);
                if (result.out_first !== want.out_first)
                    report_mismatch("out_first", result.out_first, want.out_first);
                if (result.out_second !== want.out_second)
                    report_mismatch("out_second", result.out_second, want.out_second);
                if (result.out_third !== want.out_third)
                    report_mismatch("out_third", result.out_third, want.out_third);
                if (result.test_flag !== want.test_flag)
                    report_mismatch("test_flag", 32'(result.test_flag),
                                    32'(want.test_flag));
                if (result.status !== want.status)
                    report_mismatch("status", 32'(result.status), 32'(want.status));
            end
        end
    end

    task automatic write_reg(input logic [qau_pkg::IDX_W-1:0] idx,
                             input logic [qau_pkg::CFG_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            qau_pkg::CFG_ZERO_THR:  zero_thr = val;
            qau_pkg::CFG_EQUAL_TOL: eq_tol = val;
            default:                unit_tol = val;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_word();
        int v;
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2:
            begin
                v = int'($urandom_range(0, 262144)) - 131072;
                return v;
            end
            3:
                case ($urandom_range(0, 5))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h0000_0000;
                    3: return 32'h0000_0001;
                    4: return 32'hffff_ffff;
                    default: return 32'h0001_0000;
                endcase
            4:
            begin
                v = 65536 + int'($urandom_range(0, 400)) - 200;
                return ($urandom_range(0, 1) != 0) ? -v : v;
            end
            default: return $signed($urandom) >>> $urandom_range(4, 20);
        endcase
    endfunction

    function automatic qau_pkg::request_t make_request(input logic [qau_pkg::CMD_W-1:0] cmd,
            input logic [31:0] ar, input logic [31:0] ai, input logic [31:0] aj,
            input logic [31:0] ak, input logic [31:0] br, input logic [31:0] bi,
            input logic [31:0] bj, input logic [31:0] bk, input logic [31:0] sv);
        qau_pkg::request_t r;
        r.command = cmd;
        r.a_real = ar;
        r.a_first = ai;
        r.a_second = aj;
        r.a_third = ak;
        r.b_real = br;
        r.b_first = bi;
        r.b_second = bj;
        r.b_third = bk;
        r.scalar_value = sv;
        return r;
    endfunction

    function automatic qau_pkg::request_t random_request();
        qau_pkg::request_t r;
        int                v;
        r.command = ($urandom_range(0, 99) < 92) ? qau_pkg::CMD_W'($urandom_range(0, 9))
                                                 : qau_pkg::CMD_W'($urandom_range(10, 15));
        r.a_real = pick_word();
        r.a_first = pick_word();
        r.a_second = pick_word();
        r.a_third = pick_word();
        r.b_real = pick_word();
        r.b_first = pick_word();
        r.b_second = pick_word();
        r.b_third = pick_word();
        r.scalar_value = pick_word();
        if (r.command == qau_pkg::CMD_EQUAL && $urandom_range(0, 1) != 0)
        begin
            v = int'($urandom_range(0, 2 * eq_tol + 2)) - int'(eq_tol) - 1;
            r.b_real = r.a_real + v;
            r.b_first = r.a_first;
            r.b_second = r.a_second - (v >>> 1);
            r.b_third = r.a_third + ($urandom_range(0, 1) != 0 ? 0 : v);
        end
        if (r.command == qau_pkg::CMD_UNIT && $urandom_range(0, 1) != 0)
        begin
            r.a_real = 65536 + int'($urandom_range(0, 200)) - 100;
            r.a_first = int'($urandom_range(0, 200)) - 100;
            r.a_second = int'($urandom_range(0, 20)) - 10;
            r.a_third = int'($urandom_range(0, 2000)) - 1000;
        end
        if (zero_thr == 0 && (r.command == qau_pkg::CMD_DIVIDE
                              || r.command == qau_pkg::CMD_INVERSE
                              || r.command == qau_pkg::CMD_NORMALIZE))
            r.command = qau_pkg::CMD_NORM;
        return r;
    endfunction

    task automatic drain();
        do
            @(negedge clk);
        while (pending.size() != 0 || start || awaited.size() != 0);
    endtask

    initial
    begin
        logic [qau_pkg::CFG_W-1:0] zt_set[6];
        logic [qau_pkg::CFG_W-1:0] et_set[6];
        logic [qau_pkg::CFG_W-1:0] ut_set[6];
        zt_set = '{17'd1, 17'd0, 17'd65536, 17'd16, 17'd1, 17'd300};
        et_set = '{17'd1, 17'd65536, 17'd0, 17'd300, 17'd1, 17'd7};
        ut_set = '{17'd66, 17'd0, 17'd65536, 17'd1000, 17'd66, 17'd5};
        zt_set[5] = qau_pkg::CFG_W'($urandom_range(0, 65536));
        et_set[5] = qau_pkg::CFG_W'($urandom_range(0, 65536));
        ut_set[5] = qau_pkg::CFG_W'($urandom_range(0, 65536));
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(qau_pkg::CFG_ZERO_THR, zt_set[ph]);
            write_reg(qau_pkg::CFG_EQUAL_TOL, et_set[ph]);
            write_reg(qau_pkg::CFG_UNIT_TOL, ut_set[ph]);
            quiet = (ph == 4);
            if (ph == 0)
            begin
                pending.push_back(make_request(qau_pkg::CMD_ADD, 32'h7fffffff,
                    32'h80000000, 1, 0, 32'h7fffffff, 32'h80000000, 32'hffffffff, 0, 0));
                pending.push_back(make_request(qau_pkg::CMD_SUB, 32'h80000000,
                    32'h7fffffff, 5, 0, 1, 32'hffffffff, 5, 0, 0));
                pending.push_back(make_request(qau_pkg::CMD_SCALE, 32'h00018000,
                    32'hffff8000, 3, 32'h7fffffff, 0, 0, 0, 0, 32'h00008000));
                pending.push_back(make_request(qau_pkg::CMD_SCALE, 32'h80000000,
                    32'h7fffffff, 1, 2, 0, 0, 0, 0, 32'h80000000));
                pending.push_back(make_request(qau_pkg::CMD_DIVIDE, 32'h00010000,
                    32'hfffe0000, 3, 0, 0, 0, 0, 0, 0));
                pending.push_back(make_request(qau_pkg::CMD_DIVIDE, 32'h00010000,
                    32'hfffe0000, 3, 32'h80000000, 0, 0, 0, 0, 32'hffff0000));
                pending.push_back(make_request(qau_pkg::CMD_DIVIDE, 32'h7fffffff,
                    32'h80000000, 1, 0, 0, 0, 0, 0, 1));
                pending.push_back(make_request(qau_pkg::CMD_PRODUCT, 32'h00010000,
                    32'h00020000, 32'h00030000, 32'h00040000, 32'h00050000,
                    32'hfffa0000, 32'h00070000, 32'h00008000, 0));
                pending.push_back(make_request(qau_pkg::CMD_PRODUCT, 32'h80000000,
                    32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                    32'h7fffffff, 32'h80000000, 32'h7fffffff, 0));
                pending.push_back(make_request(qau_pkg::CMD_INVERSE, 32'h00010000,
                    32'h00010000, 0, 0, 0, 0, 0, 0, 0));
                pending.push_back(make_request(qau_pkg::CMD_INVERSE, 0, 0, 0, 0,
                    0, 0, 0, 0, 0));
                pending.push_back(make_request(qau_pkg::CMD_INVERSE, 1, 1, 1, 1,
                    0, 0, 0, 0, 0));
                pending.push_back(make_request(qau_pkg::CMD_NORMALIZE, 32'h00030000,
                    32'h00040000, 0, 0, 0, 0, 0, 0, 0));
                pending.push_back(make_request(qau_pkg::CMD_NORMALIZE, 0, 0, 0, 0,
                    0, 0, 0, 0, 0));
                pending.push_back(make_request(qau_pkg::CMD_NORMALIZE, 32'h80000000,
                    32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0, 0));
                pending.push_back(make_request(qau_pkg::CMD_NORM, 32'h80000000,
                    32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0, 0));
                pending.push_back(make_request(qau_pkg::CMD_NORM, 32'h7fffffff, 1, 0, 0,
                    0, 0, 0, 0, 0));
                pending.push_back(make_request(qau_pkg::CMD_EQUAL, 5, 6, 7, 8,
                    5, 6, 7, 8, 0));
                pending.push_back(make_request(qau_pkg::CMD_EQUAL, 5, 6, 7, 8,
                    5, 6, 7, 9, 0));
                pending.push_back(make_request(qau_pkg::CMD_EQUAL, 32'h80000000, 0, 0, 0,
                    32'h7fffffff, 0, 0, 0, 0));
                pending.push_back(make_request(qau_pkg::CMD_UNIT, 32'h00010000, 0, 0, 0,
                    0, 0, 0, 0, 0));
                pending.push_back(make_request(qau_pkg::CMD_UNIT, 32'h00010042, 0, 0, 0,
                    0, 0, 0, 0, 0));
                pending.push_back(make_request(qau_pkg::CMD_UNIT, 32'h80000000,
                    32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0, 0));
                pending.push_back(make_request(4'd10, 1, 2, 3, 4, 5, 6, 7, 8, 9));
                pending.push_back(make_request(4'd15, 32'hffffffff, 32'hffffffff,
                    32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                    32'hffffffff, 32'hffffffff, 32'hffffffff));
            end
            for (int n = 0; n < 115; n++)
                pending.push_back(random_request());
            drain();
        end
        repeat (100) @(posedge clk);
        if (errors == 0 && awaited.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
